// ===== hw/rtl/rov_pkg.sv =====
`default_nettype none
package rov_pkg;

	localparam int VEL_W   = 32;
	localparam int FRC_W   = 48;
	localparam int CMD_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int STEP_W  = 17;
	localparam int COEF_W  = 23;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// velocity vector, surge in the lowest lane, then sway, heave, yaw rate
	typedef logic [3:0][VEL_W-1:0] st_t;
	// generalized forces: surge force, heave force, yaw moment
	typedef logic [2:0][FRC_W-1:0] frc_t;

	localparam int FX = 0;
	localparam int FZ = 1;
	localparam int FN = 2;

	typedef struct packed {
		logic signed [CMD_W-1:0] slo;
		logic signed [CMD_W-1:0] shi;
		logic [GAIN_W-1:0]       lgf;
		logic [GAIN_W-1:0]       lgr;
		logic [GAIN_W-1:0]       vgf;
		logic [GAIN_W-1:0]       vgr;
	} cfg_t;

	localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_FWD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_REV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_FWD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_REV = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd6;

	// Q6.16 model coefficients
	localparam logic signed [COEF_W-1:0] C_XUD = 23'sd127140;
	localparam logic signed [COEF_W-1:0] C_YVD = 23'sd396493;
	localparam logic signed [COEF_W-1:0] C_XU  = -23'sd62259;
	localparam logic signed [COEF_W-1:0] C_YV  = -23'sd384696;
	localparam logic signed [COEF_W-1:0] C_NR  = -23'sd1507;
	localparam logic signed [COEF_W-1:0] C_ZW  = -23'sd242483;
	localparam logic signed [COEF_W-1:0] C_XUU = -23'sd395837;
	localparam logic signed [COEF_W-1:0] C_YVV = -23'sd2013921;
	localparam logic signed [COEF_W-1:0] C_NRR = -23'sd29491;
	localparam logic signed [COEF_W-1:0] C_ZWW = -23'sd1727529;

	// linear drag per lane u, v, w, r
	localparam logic signed [COEF_W-1:0] COEF_LIN [4] = '{C_XU, C_YV, C_ZW, C_NR};
	// product terms: v*r, u*r, u|u|, v|v|, w|w|, r|r|
	localparam logic signed [COEF_W-1:0] COEF_QUAD [6] =
		'{-C_YVD, C_XUD, C_XUU, C_YVV, C_ZWW, C_NRR};

	// added mass per lane
	localparam int unsigned MASS [4] = '{127140, 396493, 258867, 773};
	// 6 * 65536 for the final weighted sum
	localparam int unsigned RK_DIV = 393216;

	localparam int THR_LAT = 3;
	localparam int DER_LAT = 10;
	localparam int RK_LAT  = 2;
	localparam int FIN_LAT = 8;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] a);
		if (a > 72'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (a < -72'sd2147483648) begin
			return 32'sh80000000;
		end
		return a[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rov_thrust_and_dynamics_step_top.sv =====
// Thruster mixing and one RK4 step of a 4-DOF vehicle model, fully pipelined.
// Input stream s_*: three throttle commands and the measured surge, sway,
// heave and yaw velocities. Output stream m_*: the four velocities after
// one step, in the same fixed-point format, saturated to 32 bits.
// Config port cfg_*: index 0..6 selects clamp low/high, lateral gains,
// vertical gains and step size; always ready, write only between items.
// Stages in order: thrust mixing, four derivative evaluations (products,
// drag terms, sum, reciprocal divide by the added mass) with an intermediate
// RK state after each of the first three, then the weighted sum and its
// constant divide. One item is taken every cycle unless the output is held.
// A stall on m_tready freezes the whole pipeline in place and drops
// s_tready in the same cycle; nothing is lost or repeated.
// Reset clears the pipeline valid bits and loads the default register
// values; the datapath needs no clearing.
`default_nettype none
module rov_thrust_and_dynamics_step_top
	import rov_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// port, starboard, vertical commands (16 each), surge, sway, heave, yaw (32 each)
	input  wire logic [175:0]          s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// surge_out, sway_out, heave_out, yaw_rate_out (32 each)
	output logic [127:0]               m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int T_K1 = THR_LAT + DER_LAT;
	localparam int T_S1 = T_K1 + RK_LAT;
	localparam int T_K2 = T_S1 + DER_LAT;
	localparam int T_S2 = T_K2 + RK_LAT;
	localparam int T_K3 = T_S2 + DER_LAT;
	localparam int T_S3 = T_K3 + RK_LAT;
	localparam int T_K4 = T_S3 + DER_LAT;
	localparam int LAT  = T_K4 + FIN_LAT;
	localparam int ST_W = $bits(st_t);
	localparam int FR_W = $bits(frc_t);

	cfg_t              cfg_q;
	logic [STEP_W-1:0] step_q;
	logic [LAT-1:0]    vld_q;
	logic              en;

	st_t  x_in, x_k1, x_s1, x_s2, x_s3, x_fin;
	frc_t frc, frc_k2, frc_k3, frc_k4;
	st_t  k1, k2, k3, k4, k1_d, k2_d, k3_d;
	st_t  st1, st2, st3, y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slo <= -16'sd150;
			cfg_q.shi <= 16'sd150;
			cfg_q.lgf <= 16'd1748;
			cfg_q.lgr <= 16'd1748;
			cfg_q.vgf <= 16'd1748;
			cfg_q.vgr <= 16'd1748;
			step_q    <= 17'd6554;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAT_LOW:  cfg_q.slo <= cfg_data[CMD_W-1:0];
				REG_SAT_HIGH: cfg_q.shi <= cfg_data[CMD_W-1:0];
				REG_LAT_FWD:  cfg_q.lgf <= cfg_data[GAIN_W-1:0];
				REG_LAT_REV:  cfg_q.lgr <= cfg_data[GAIN_W-1:0];
				REG_VERT_FWD: cfg_q.vgf <= cfg_data[GAIN_W-1:0];
				REG_VERT_REV: cfg_q.vgr <= cfg_data[GAIN_W-1:0];
				REG_STEP:     step_q    <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// whole pipeline advances together unless the output is held
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	assign x_in = s_tdata[175:48];

	rov_thrust #(.FRAC_BITS(FRAC_BITS)) u_thrust (
		.clk (clk),
		.en  (en),
		.cfg (cfg_q),
		.cmd (s_tdata[47:0]),
		.frc (frc)
	);

	rov_dly #(.W(ST_W), .DEPTH(THR_LAT)) u_dx0 (.clk(clk), .en(en), .d(x_in), .q(x_k1));
	rov_dly #(.W(ST_W), .DEPTH(T_K1 - THR_LAT)) u_dx1 (.clk(clk), .en(en), .d(x_k1), .q(x_s1));
	rov_dly #(.W(ST_W), .DEPTH(T_K2 - T_K1)) u_dx2 (.clk(clk), .en(en), .d(x_s1), .q(x_s2));
	rov_dly #(.W(ST_W), .DEPTH(T_K3 - T_K2)) u_dx3 (.clk(clk), .en(en), .d(x_s2), .q(x_s3));
	rov_dly #(.W(ST_W), .DEPTH(T_K4 - T_K3)) u_dx4 (.clk(clk), .en(en), .d(x_s3), .q(x_fin));

	rov_dly #(.W(FR_W), .DEPTH(T_S1 - THR_LAT)) u_df1 (.clk(clk), .en(en), .d(frc), .q(frc_k2));
	rov_dly #(.W(FR_W), .DEPTH(T_S2 - T_S1)) u_df2 (.clk(clk), .en(en), .d(frc_k2), .q(frc_k3));
	rov_dly #(.W(FR_W), .DEPTH(T_S3 - T_S2)) u_df3 (.clk(clk), .en(en), .d(frc_k3), .q(frc_k4));

	rov_deriv #(.FRAC_BITS(FRAC_BITS)) u_der1 (
		.clk(clk), .en(en), .s(x_k1), .f(frc), .k(k1)
	);
	rov_rkst #(.SH(17)) u_rk1 (
		.clk(clk), .en(en), .h(step_q), .x(x_s1), .k(k1), .y(st1)
	);
	rov_deriv #(.FRAC_BITS(FRAC_BITS)) u_der2 (
		.clk(clk), .en(en), .s(st1), .f(frc_k2), .k(k2)
	);
	rov_rkst #(.SH(17)) u_rk2 (
		.clk(clk), .en(en), .h(step_q), .x(x_s2), .k(k2), .y(st2)
	);
	rov_deriv #(.FRAC_BITS(FRAC_BITS)) u_der3 (
		.clk(clk), .en(en), .s(st2), .f(frc_k3), .k(k3)
	);
	rov_rkst #(.SH(16)) u_rk3 (
		.clk(clk), .en(en), .h(step_q), .x(x_s3), .k(k3), .y(st3)
	);
	rov_deriv #(.FRAC_BITS(FRAC_BITS)) u_der4 (
		.clk(clk), .en(en), .s(st3), .f(frc_k4), .k(k4)
	);

	rov_dly #(.W(ST_W), .DEPTH(T_K4 - T_K1)) u_dk1 (.clk(clk), .en(en), .d(k1), .q(k1_d));
	rov_dly #(.W(ST_W), .DEPTH(T_K4 - T_K2)) u_dk2 (.clk(clk), .en(en), .d(k2), .q(k2_d));
	rov_dly #(.W(ST_W), .DEPTH(T_K4 - T_K3)) u_dk3 (.clk(clk), .en(en), .d(k3), .q(k3_d));

	rov_rkfin u_fin (
		.clk (clk),
		.en  (en),
		.h   (step_q),
		.x   (x_fin),
		.k1  (k1_d),
		.k2  (k2_d),
		.k3  (k3_d),
		.k4  (k4),
		.y   (y)
	);

	assign m_tdata = y;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output not held");

	a_transfer_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted item missing from first stage");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== hw/rtl/rov_dly.sv =====
`default_nettype none
module rov_dly #(
	parameter int W     = 128,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] sh_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

	assign q = sh_q[DEPTH-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rov_cdiv.sv =====
`default_nettype none
module rov_cdiv #(
	parameter int          WN  = 50,
	parameter int unsigned DIV = 773,
	parameter int          WU  = 2
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [WN-1:0] n,
	input  wire logic [WU-1:0] u_in,
	output logic      [WN-1:0] q,
	output logic      [WU-1:0] u_out
);

	localparam int WL = WN / 2;
	localparam int WH = WN - WL;
	localparam int WQ = WN - $clog2(DIV) + 1;
	localparam int WD = $clog2(DIV + 1);
	localparam logic [63:0] RECIP = (64'd1 << WN) / 64'(DIV);
	localparam logic [WQ-1:0] RCP = RECIP[WQ-1:0];
	localparam logic [WD-1:0] DIV_C = WD'(DIV);

	logic [WL+WQ-1:0]  plo_s1;
	logic [WH+WQ-1:0]  phi_s1;
	logic [WN-1:0]     n_s1, n_s2, n_s3;
	logic [WU-1:0]     u_s1, u_s2, u_s3, u_s4;
	logic [WN+WQ:0]    tot;
	logic [WQ-1:0]     qe_s2, qe_s3;
	logic [WQ+WD-1:0]  pm_s3;
	logic [WN:0]       rem;
	logic [WQ-1:0]     q_s4;

	// estimate floor(n / DIV) by reciprocal, low by at most one
	assign tot = (WN+WQ+1)'({phi_s1, {WL{1'b0}}}) + (WN+WQ+1)'(plo_s1);
	assign rem = (WN+1)'(n_s3) - (WN+1)'(pm_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= (WL+WQ)'(n[WL-1:0]) * (WL+WQ)'(RCP);
			phi_s1 <= (WH+WQ)'(n[WN-1:WL]) * (WH+WQ)'(RCP);
			n_s1   <= n;
			u_s1   <= u_in;

			qe_s2  <= tot[WN +: WQ];
			n_s2   <= n_s1;
			u_s2   <= u_s1;

			pm_s3  <= (WQ+WD)'(qe_s2) * (WQ+WD)'(DIV_C);
			qe_s3  <= qe_s2;
			n_s3   <= n_s2;
			u_s3   <= u_s2;

			q_s4   <= (rem >= (WN+1)'(DIV_C)) ? qe_s3 + WQ'(1) : qe_s3;
			u_s4   <= u_s3;
		end
	end

	assign q     = WN'(q_s4);
	assign u_out = u_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/rov_thrust.sv =====
`default_nettype none
module rov_thrust
	import rov_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire cfg_t                 cfg,
	input  wire logic [2:0][CMD_W-1:0] cmd,
	output frc_t                      frc
);

	logic signed [CMD_W-1:0]  cc [3];
	logic [GAIN_W-1:0]        gg [3];
	logic signed [CMD_W-1:0]  c_s1 [3];
	logic [GAIN_W-1:0]        g_s1 [3];
	logic signed [32:0]       p_s2 [3];
	logic signed [FRC_W-1:0]  t [3];
	frc_t                     frc_s3;

	function automatic logic signed [CMD_W-1:0] clamp(
		input logic signed [CMD_W-1:0] c,
		input logic signed [CMD_W-1:0] lo,
		input logic signed [CMD_W-1:0] hi
	);
		if (lo > hi) begin
			return '0;
		end else if (c < lo) begin
			return lo;
		end else if (c > hi) begin
			return hi;
		end
		return c;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cc[i] = clamp($signed(cmd[i]), cfg.slo, cfg.shi);
			if (i == 2) begin
				gg[i] = cc[i][CMD_W-1] ? cfg.vgr : cfg.vgf;
			end else begin
				gg[i] = cc[i][CMD_W-1] ? cfg.lgr : cfg.lgf;
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_frac
		if (FRAC_BITS >= 16) begin : g_up
			assign t[i] = FRC_W'(p_s2[i]) <<< (FRAC_BITS - 16);
		end else begin : g_dn
			assign t[i] = FRC_W'((34'(p_s2[i]) + (34'sd1 <<< (15 - FRAC_BITS)))
				>>> (16 - FRAC_BITS));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s1[i] <= cc[i];
				g_s1[i] <= gg[i];
				p_s2[i] <= 33'(c_s1[i]) * 33'($signed({1'b0, g_s1[i]}));
			end
			// port is lane 0, starboard lane 1
			frc_s3[FX] <= t[0] + t[1];
			frc_s3[FN] <= t[1] - t[0];
			frc_s3[FZ] <= t[2];
		end
	end

	assign frc = frc_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/rov_deriv.sv =====
`default_nettype none
module rov_deriv
	import rov_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic en,
	input  wire st_t  s,
	input  wire frc_t f,
	output st_t       k
);

	logic signed [31:0]      sv [4];
	logic signed [32:0]      a [4];
	logic signed [65:0]      m_s1 [6];
	st_t                     s_s1;
	frc_t                    f_s1, f_s2, f_s3;
	logic signed [31:0]      fm [6];
	logic signed [31:0]      fm_s2 [6];
	logic signed [54:0]      pl_s2 [4];
	logic signed [54:0]      pq_s3 [6];
	logic signed [39:0]      tl_s3 [4];
	logic signed [39:0]      tq [6];
	logic signed [FRC_W-1:0] num [4];
	logic signed [FRC_W-1:0] num_s4 [4];
	logic [FRC_W-1:0]        mabs [4];
	logic [33:0]             mag_s5 [4];
	logic                    neg_s5 [4];
	logic                    sat_s5 [4];
	logic [49:0]             q [4];
	logic [1:0]              ud [4];
	st_t                     k_s10;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sv[i] = $signed(s[i]);
			a[i]  = (sv[i] < 0) ? -33'(sv[i]) : 33'(sv[i]);
		end
		for (int j = 0; j < 6; j++) begin
			fm[j] = sat32(72'((m_s1[j] + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
			tq[j] = 40'((pq_s3[j] + 55'sd32768) >>> 16);
		end
		num[0] = FRC_W'(tq[0]) + FRC_W'(tl_s3[0]) + FRC_W'(tq[2]) + $signed(f_s3[FX]);
		num[1] = FRC_W'(tq[1]) + FRC_W'(tl_s3[1]) + FRC_W'(tq[3]);
		num[2] = FRC_W'(tl_s3[2]) + FRC_W'(tq[4]) + $signed(f_s3[FZ]);
		num[3] = FRC_W'(tl_s3[3]) + FRC_W'(tq[5]) + $signed(f_s3[FN]);
		for (int i = 0; i < 4; i++) begin
			mabs[i] = num_s4[i][FRC_W-1] ? FRC_W'(-num_s4[i]) : FRC_W'(num_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= 66'(sv[1]) * 66'(sv[3]);
			m_s1[1] <= 66'(sv[0]) * 66'(sv[3]);
			m_s1[2] <= 66'(sv[0]) * 66'(a[0]);
			m_s1[3] <= 66'(sv[1]) * 66'(a[1]);
			m_s1[4] <= 66'(sv[2]) * 66'(a[2]);
			m_s1[5] <= 66'(sv[3]) * 66'(a[3]);
			s_s1    <= s;
			f_s1    <= f;

			for (int j = 0; j < 6; j++) begin
				fm_s2[j] <= fm[j];
				pq_s3[j] <= 55'(COEF_QUAD[j]) * 55'(fm_s2[j]);
			end
			for (int i = 0; i < 4; i++) begin
				pl_s2[i] <= 55'(COEF_LIN[i]) * 55'($signed(s_s1[i]));
				tl_s3[i] <= 40'((pl_s2[i] + 55'sd32768) >>> 16);
				num_s4[i] <= num[i];
				// quotient reaches 2^31 exactly when |num| >= 2^15 * mass
				sat_s5[i] <= mabs[i] >= (FRC_W'(MASS[i]) << 15);
				neg_s5[i] <= num_s4[i][FRC_W-1];
				mag_s5[i] <= mabs[i][33:0];
			end
			f_s2 <= f_s1;
			f_s3 <= f_s2;

			for (int i = 0; i < 4; i++) begin
				if (ud[i][1]) begin
					k_s10[i] <= ud[i][0] ? 32'h80000000 : 32'h7fffffff;
				end else begin
					k_s10[i] <= ud[i][0] ? -q[i][31:0] : q[i][31:0];
				end
			end
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		rov_cdiv #(
			.WN  (50),
			.DIV (MASS[i]),
			.WU  (2)
		) u_div (
			.clk   (clk),
			.en    (en),
			.n     ({mag_s5[i], 16'b0}),
			.u_in  ({sat_s5[i], neg_s5[i]}),
			.q     (q[i]),
			.u_out (ud[i])
		);
	end

	assign k = k_s10;

endmodule
`default_nettype wire

// ===== hw/rtl/rov_rkst.sv =====
`default_nettype none
module rov_rkst
	import rov_pkg::*;
#(
	parameter int SH = 17
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [STEP_W-1:0] h,
	input  wire st_t               x,
	input  wire st_t               k,
	output st_t                    y
);

	logic signed [49:0] p_s1 [4];
	st_t                x_s1;
	logic signed [50:0] pr [4];
	logic signed [71:0] sm [4];
	st_t                y_s2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pr[i] = (51'(p_s1[i]) + (51'sd1 <<< (SH - 1))) >>> SH;
			sm[i] = 72'(pr[i]) + 72'($signed(x_s1[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				p_s1[i] <= 50'($signed({1'b0, h})) * 50'($signed(k[i]));
				y_s2[i] <= sat32(sm[i]);
			end
			x_s1 <= x;
		end
	end

	assign y = y_s2;

endmodule
`default_nettype wire

// ===== hw/rtl/rov_rkfin.sv =====
`default_nettype none
module rov_rkfin
	import rov_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [STEP_W-1:0] h,
	input  wire st_t               x,
	input  wire st_t               k1,
	input  wire st_t               k2,
	input  wire st_t               k3,
	input  wire st_t               k4,
	output st_t                    y
);

	logic signed [34:0] sum_s1 [4];
	logic signed [52:0] p_s2 [4];
	st_t                x_s1, x_s2, x_s3;
	logic [51:0]        mag_s3 [4];
	logic               neg_s3 [4];
	logic [51:0]        q [4];
	logic [32:0]        ud [4];
	logic signed [71:0] qs [4];
	logic signed [71:0] sm [4];
	st_t                y_s8;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qs[i] = $signed(72'(q[i]));
			sm[i] = 72'($signed(ud[i][31:0])) + (ud[i][32] ? -qs[i] : qs[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sum_s1[i] <= 35'($signed(k1[i])) + (35'($signed(k2[i])) <<< 1)
					+ (35'($signed(k3[i])) <<< 1) + 35'($signed(k4[i]));
				p_s2[i]   <= 53'($signed({1'b0, h})) * 53'(sum_s1[i]);
				neg_s3[i] <= p_s2[i][52];
				mag_s3[i] <= p_s2[i][52] ? 52'(-p_s2[i]) : 52'(p_s2[i]);
				y_s8[i]   <= sat32(sm[i]);
			end
			x_s1 <= x;
			x_s2 <= x_s1;
			x_s3 <= x_s2;
		end
	end

	// truncation toward zero: divide the magnitude, then put the sign back
	for (genvar i = 0; i < 4; i++) begin : g_div
		rov_cdiv #(
			.WN  (52),
			.DIV (RK_DIV),
			.WU  (33)
		) u_div (
			.clk   (clk),
			.en    (en),
			.n     (mag_s3[i]),
			.u_in  ({neg_s3[i], x_s3[i]}),
			.q     (q[i]),
			.u_out (ud[i])
		);
	end

	assign y = y_s8;

endmodule
`default_nettype wire

// ===== dv/rov_thrust_and_dynamics_step_checker.sv =====
`default_nettype none
module rov_thrust_and_dynamics_step_checker
	import rov_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [175:0]          s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [127:0]          m_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending,
	output int                         steps_seen
);

	typedef longint vec4_t [4];

	longint lim_lo, lim_hi, lat_fwd, lat_rev, vert_fwd, vert_rev, dt;
	logic [127:0] next_vel_q [$];

	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// divide by 2^s, round half up
	function automatic longint round_shr(input longint x, input int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint drag(input longint coef, input longint val);
		return round_shr(coef * val, 16);
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return clip32(round_shr(a * b, 16));
	endfunction

	function automatic longint mag(input longint a);
		return a < 0 ? -a : a;
	endfunction

	function automatic longint clamp_cmd(input longint c);
		if (lim_lo > lim_hi) return 0;
		if (c < lim_lo) return lim_lo;
		if (c > lim_hi) return lim_hi;
		return c;
	endfunction

	function automatic void accel(input vec4_t s, input longint fx, input longint fz,
		input longint fn, output vec4_t d);
		longint num [4];
		num[0] = drag(-longint'(C_YVD), qmul(s[1], s[3])) + drag(longint'(C_XU), s[0])
			+ drag(longint'(C_XUU), qmul(s[0], mag(s[0]))) + fx;
		num[1] = drag(longint'(C_XUD), qmul(s[0], s[3])) + drag(longint'(C_YV), s[1])
			+ drag(longint'(C_YVV), qmul(s[1], mag(s[1])));
		num[2] = drag(longint'(C_ZW), s[2]) + drag(longint'(C_ZWW), qmul(s[2], mag(s[2])))
			+ fz;
		num[3] = drag(longint'(C_NR), s[3]) + drag(longint'(C_NRR), qmul(s[3], mag(s[3])))
			+ fn;
		for (int i = 0; i < 4; i++) d[i] = clip32((num[i] * 65536) / longint'(MASS[i]));
	endfunction

	function automatic logic [127:0] rk4_step(input logic [175:0] item);
		longint cp, cs, cv, tp, ts, fx, fz, fn, sum;
		vec4_t x, st, k1, k2, k3, k4;
		logic [127:0] res;
		cp = clamp_cmd(longint'($signed(item[15:0])));
		cs = clamp_cmd(longint'($signed(item[31:16])));
		cv = clamp_cmd(longint'($signed(item[47:32])));
		tp = cp * (cp >= 0 ? lat_fwd : lat_rev);
		ts = cs * (cs >= 0 ? lat_fwd : lat_rev);
		fz = cv * (cv >= 0 ? vert_fwd : vert_rev);
		fx = tp + ts;
		fn = ts - tp;
		for (int i = 0; i < 4; i++) x[i] = longint'($signed(item[48+32*i +: 32]));
		accel(x, fx, fz, fn, k1);
		for (int i = 0; i < 4; i++) st[i] = clip32(x[i] + round_shr(dt * k1[i], 17));
		accel(st, fx, fz, fn, k2);
		for (int i = 0; i < 4; i++) st[i] = clip32(x[i] + round_shr(dt * k2[i], 17));
		accel(st, fx, fz, fn, k3);
		for (int i = 0; i < 4; i++) st[i] = clip32(x[i] + round_shr(dt * k3[i], 16));
		accel(st, fx, fz, fn, k4);
		for (int i = 0; i < 4; i++) begin
			sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
			res[32*i +: 32] = 32'(clip32(x[i] + (dt * sum) / longint'(RK_DIV)));
		end
		return res;
	endfunction

	assign pending = next_vel_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			lim_lo = -150;
			lim_hi = 150;
			lat_fwd = 1748;
			lat_rev = 1748;
			vert_fwd = 1748;
			vert_rev = 1748;
			dt = 6554;
			errors = 0;
			steps_seen = 0;
			next_vel_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAT_LOW:  lim_lo = longint'($signed(cfg_data[15:0]));
					REG_SAT_HIGH: lim_hi = longint'($signed(cfg_data[15:0]));
					REG_LAT_FWD:  lat_fwd = longint'(cfg_data[15:0]);
					REG_LAT_REV:  lat_rev = longint'(cfg_data[15:0]);
					REG_VERT_FWD: vert_fwd = longint'(cfg_data[15:0]);
					REG_VERT_REV: vert_rev = longint'(cfg_data[15:0]);
					REG_STEP:     dt = longint'(cfg_data);
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (next_vel_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transfer, actual %h", $time, m_tdata);
				end else begin
					want = next_vel_q.pop_front();
					steps_seen++;
					for (int i = 0; i < 4; i++) begin
						if (want[32*i +: 32] !== m_tdata[32*i +: 32]) begin
							errors++;
							$display("%0t: velocity lane %0d expected %0d actual %0d", $time, i,
								$signed(want[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
						end
					end
				end
			end
			if (s_tvalid && s_tready) next_vel_q.push_back(rk4_step(s_tdata));
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_rov_thrust_and_dynamics_step_top.sv =====
`default_nettype none
module tb_rov_thrust_and_dynamics_step_top;
	import rov_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// port, starboard, vertical commands (16 each), surge, sway, heave, yaw (32 each)
	logic [175:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// surge_out, sway_out, heave_out, yaw_rate_out (32 each)
	logic [127:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending, steps_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int cycles = 0;

	rov_thrust_and_dynamics_step_top dut (.*);

	rov_thrust_and_dynamics_step_checker checker_i (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .steps_seen
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
				@(posedge clk);
			end
		end
	end

	task automatic send_step(input logic [175:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_all(input int lo, input int hi, input int lf, input int lr,
		input int vf, input int vr, input int dt);
		write_reg(REG_SAT_LOW, 17'(lo & 16'hffff));
		write_reg(REG_SAT_HIGH, 17'(hi & 16'hffff));
		write_reg(REG_LAT_FWD, 17'(lf));
		write_reg(REG_LAT_REV, 17'(lr));
		write_reg(REG_VERT_FWD, 17'(vf));
		write_reg(REG_VERT_REV, 17'(vr));
		write_reg(REG_STEP, 17'(dt));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [175:0] pack_step(input logic [15:0] cp, input logic [15:0] cs,
		input logic [15:0] cv, input logic [31:0] u, input logic [31:0] v,
		input logic [31:0] w, input logic [31:0] r);
		return {r, w, v, u, cv, cs, cp};
	endfunction

	function automatic logic [15:0] rand_cmd();
		if ($urandom_range(1)) return 16'($urandom);
		return 16'($urandom_range(600)) - 16'd300;
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(4))
			0: return $urandom;
			1: return 32'($urandom_range(1048576)) - 32'd524288;
			2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
				: 32'h80000000 + $urandom_range(255);
			default: return 32'($urandom_range(131072)) - 32'd65536;
		endcase
	endfunction

	task automatic extremes();
		send_step(pack_step(16'h7fff, 16'h8000, 16'h7fff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		send_step(pack_step(16'h8000, 16'h7fff, 16'h8000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
		send_step(pack_step(16'h0000, 16'hffff, 16'h0001,
			32'h0, 32'hffffffff, 32'h1, 32'h00010000));
	endtask

	task automatic run_phase(input int n, input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
			default: begin send_idle_pct = 10; recv_stall_pct = 10; end
		endcase
		extremes();
		for (int i = 0; i < n; i++)
			send_step(pack_step(rand_cmd(), rand_cmd(), rand_cmd(),
				rand_vel(), rand_vel(), rand_vel(), rand_vel()));
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: clamp edges, zero state and the saturating corners
		send_step(pack_step(16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0));
		send_step(pack_step(16'd150, 16'd151, -16'd150, 32'h00010000, 32'hffff0000,
			32'h00008000, 32'hffff8000));
		send_step(pack_step(-16'd151, 16'd149, 16'd151, 32'h00050000, 32'd0,
			32'hfffb0000, 32'h00020000));
		run_phase(20, 0);

		// sender keeps offering while the receiver holds off, so the pipe fills
		hold_req = 1;
		write_all(-32768, 32767, 65535, 65535, 65535, 65535, 65536);
		run_phase(85, 0);

		// inverted limits give zero thrust; zero step leaves the state alone
		write_all(100, -100, 1000, 30000, 0, 65535, 0);
		run_phase(80, 1);

		// step above one second
		write_all(-32768, 32767, 0, 0, 65535, 0, 131071);
		run_phase(80, 2);

		write_all(int'($urandom_range(400)) - 400, $urandom_range(400), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(20000));
		run_phase(85, 3);

		write_reg(REG_UNUSED, 17'h1ffff);
		write_all(-150, 150, 1748, 1748, 1748, 1748, 6554);
		run_phase(85, 1);

		write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(131071));
		run_phase(85, 2);

		write_all(-1000, 1000, $urandom_range(4000), $urandom_range(4000),
			$urandom_range(4000), $urandom_range(4000), $urandom_range(13107));
		run_phase(85, 3);

		repeat (80) @(posedge clk);
		$display("stepped %0d vehicle states over eight register settings", steps_seen);
		$display("covered clamp extremes, inverted limits, zero and oversize steps, saturation");
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/rov_pkg.sv
hw/rtl/rov_dly.sv
hw/rtl/rov_cdiv.sv
hw/rtl/rov_thrust.sv
hw/rtl/rov_deriv.sv
hw/rtl/rov_rkst.sv
hw/rtl/rov_rkfin.sv
hw/rtl/rov_thrust_and_dynamics_step_top.sv
dv/rov_thrust_and_dynamics_step_checker.sv
dv/tb_rov_thrust_and_dynamics_step_top.sv
